### rtl/core/quadrature_index_encoder_rpm_macros.svh
// Assertion macros used by the encoder counter back end.
`ifndef QUADRATURE_INDEX_ENCODER_RPM_MACROS_SVH
`define QUADRATURE_INDEX_ENCODER_RPM_MACROS_SVH
`ifndef SYNTHESIS
`define QIE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("encoder counter assertion failed");
`define QIE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("encoder counter assertion failed");
`else
`define QIE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define QIE_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/qienc_pkg.sv
// Types and constants shared by the encoder counter modules.
`default_nettype none
package qienc_pkg;

    localparam int COUNT_W    = 16;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 26;
    localparam int DIV_CNT_W  = $clog2(SPEED_W);
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [SPEED_W-1:0] SPEED_NUM = SPEED_W'(60000000);

    localparam logic [1:0] OP_A = 2'd0;
    localparam logic [1:0] OP_B = 2'd1;
    localparam logic [1:0] OP_Z = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic              b_level;
        logic [TIME_W-1:0] timestamp_us;
    } item_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] position;
        logic [COUNT_W-1:0]        count_a;
        logic [COUNT_W-1:0]        count_b;
        logic [COUNT_W-1:0]        count_index;
        logic [SPEED_W-1:0]        rpm;
        logic                      rpm_valid;
        logic                      phase_error;
    } result_t;

    typedef struct packed {
        logic              ev_a;
        logic              ev_b;
        logic              ev_z;
        logic              b_level;
        logic [TIME_W-1:0] stamp;
    } cmd_t;

endpackage
`default_nettype wire

### rtl/core/qienc_front.sv
// Front end: accepts encoder events, decodes them and queues them for the back end.
`default_nettype none
module qienc_front
    import qienc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       cmd_valid,
    input  wire logic  cmd_ready,
    output cmd_t       cmd
);

    cmd_t              slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;
    cmd_t              decoded;

    always_comb
    begin
        decoded.ev_a    = (item.op == OP_A);
        decoded.ev_b    = (item.op == OP_B);
        decoded.ev_z    = (item.op == OP_Z);
        decoded.b_level = item.b_level;
        decoded.stamp   = item.timestamp_us;
    end

    assign full      = (fill_reg == FILL_W'(FIFO_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule
`default_nettype wire

### rtl/core/qienc_back.sv
// Back end: counter state, index period, iterative speed divider and result register.
`default_nettype none
`include "quadrature_index_encoder_rpm_macros.svh"
module qienc_back
    import qienc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire cmd_t                cmd,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic signed [15:0]  cfg_data,
    output logic                     empty,
    input  wire logic                pop,
    output result_t                  result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic signed [15:0]        offset_reg;
    logic [COUNT_W-1:0]        a_edges_reg;
    logic [COUNT_W-1:0]        a_edges_next;
    logic [COUNT_W-1:0]        b_edges_reg;
    logic [COUNT_W-1:0]        b_edges_next;
    logic [COUNT_W-1:0]        index_reg;
    logic [COUNT_W-1:0]        index_next;
    logic [COUNT_W-1:0]        angle_reg;
    logic [COUNT_W-1:0]        angle_next;
    logic [TIME_W-1:0]         stamp_reg;
    logic [TIME_W-1:0]         stamp_next;
    logic [SPEED_W-1:0]        speed_reg;
    logic [SPEED_W-1:0]        speed_next;
    logic                      speed_ok_reg;
    logic                      speed_ok_next;
    logic [TIME_W-1:0]         divisor_reg;
    logic [TIME_W-1:0]         divisor_next;
    logic [TIME_W-1:0]         rem_reg;
    logic [TIME_W-1:0]         rem_next;
    logic [SPEED_W-1:0]        quo_reg;
    logic [SPEED_W-1:0]        quo_next;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic [DIV_CNT_W-1:0]      cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   result_reg;
    result_t                   result_next;
    logic                      out_load;
    logic                      slot_free;
    logic [TIME_W-1:0]         period;
    logic [TIME_W:0]           rem_shift;
    logic [TIME_W:0]           rem_diff;
    logic                      quo_bit;
    logic [COUNT_W:0]          a_wide;
    logic [COUNT_W:0]          b_wide;

    assign cfg_ready = 1'b1;
    assign empty     = !out_valid_reg;
    assign result    = result_reg;
    assign slot_free = !out_valid_reg || pop;
    assign period    = cmd.stamp - stamp_reg;
    assign rem_shift = {rem_reg, SPEED_NUM[cnt_reg]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign quo_bit   = !rem_diff[TIME_W];

    always_comb
    begin
        state_next    = state_reg;
        a_edges_next  = a_edges_reg;
        b_edges_next  = b_edges_reg;
        index_next    = index_reg;
        angle_next    = angle_reg;
        stamp_next    = stamp_reg;
        speed_next    = speed_reg;
        speed_ok_next = speed_ok_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        out_load      = 1'b0;
        cmd_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_ready = 1'b1;
                    if (cmd.ev_a)
                    begin
                        a_edges_next = a_edges_reg + 1'b1;
                        angle_next   = cmd.b_level ? angle_reg + 1'b1 : angle_reg - 1'b1;
                        out_load     = 1'b1;
                    end
                    else if (cmd.ev_b)
                    begin
                        b_edges_next = b_edges_reg + 1'b1;
                        out_load     = 1'b1;
                    end
                    else if (cmd.ev_z)
                    begin
                        index_next   = index_reg + 1'b1;
                        a_edges_next = '0;
                        b_edges_next = '0;
                        angle_next   = COUNT_W'(offset_reg);
                        stamp_next   = cmd.stamp;
                        if (period == '0)
                        begin
                            speed_ok_next = 1'b0;
                            speed_next    = '0;
                            out_load      = 1'b1;
                        end
                        else
                        begin
                            divisor_next = period;
                            rem_next     = '0;
                            quo_next     = '0;
                            cnt_next     = DIV_CNT_W'(SPEED_W - 1);
                            state_next   = ST_DIV;
                        end
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = quo_bit ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], quo_bit};
                if (cnt_reg == '0)
                begin
                    speed_next    = quo_next;
                    speed_ok_next = 1'b1;
                    out_load      = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        a_wide                  = {1'b0, a_edges_next};
        b_wide                  = {1'b0, b_edges_next};
        result_next.position    = angle_next;
        result_next.count_a     = a_edges_next;
        result_next.count_b     = b_edges_next;
        result_next.count_index = index_next;
        result_next.rpm         = speed_ok_next ? speed_next : '0;
        result_next.rpm_valid   = speed_ok_next;
        result_next.phase_error = (a_wide > b_wide + 1'b1) || (b_wide > a_wide + 1'b1);
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            a_edges_reg   <= '0;
            b_edges_reg   <= '0;
            index_reg     <= '0;
            angle_reg     <= '0;
            stamp_reg     <= '0;
            speed_reg     <= '0;
            speed_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_edges_reg   <= a_edges_next;
            b_edges_reg   <= b_edges_next;
            index_reg     <= index_next;
            angle_reg     <= angle_next;
            stamp_reg     <= stamp_next;
            speed_reg     <= speed_next;
            speed_ok_reg  <= speed_ok_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    `QIE_ASSERT_IMP(a_div_slot_empty, clk, rst_n, state_reg == ST_DIV, !out_valid_reg)
    `QIE_ASSERT_NXT(a_zero_period_no_div, clk, rst_n,
        cmd_valid && cmd_ready && cmd.ev_z && (period == '0), state_reg == ST_IDLE)
    `QIE_ASSERT_IMP(a_speed_cleared, clk, rst_n, !speed_ok_reg, speed_reg == '0)

endmodule
`default_nettype wire

### rtl/core/quadrature_index_encoder_rpm.sv
// Top level of the quadrature encoder counter with index pulse and speed output.
//
//  Channel   Handshake            Beat
//  item      push / full          item_t: op, b_level, timestamp_us
//  result    pop / empty          result_t: position, counts, rpm, flags
//  config    cfg_valid/cfg_ready  cfg_data: calibration offset
//
// An A, B or unused event is taken in the idle state and loads the result register.
// An index pulse with a nonzero period starts the restoring divider, which
// produces one quotient bit of the 26-bit speed per cycle; no event is taken meanwhile.
// Reset clears all counters, stamps, the speed and the calibration offset.
// The front queue holds two events; the back end waits while a result is untaken.
`default_nettype none
module quadrature_index_encoder_rpm
    import qienc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire item_t              item,
    output logic                    empty,
    input  wire logic               pop,
    output result_t                 result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [15:0] cfg_data
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    qienc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    qienc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire

### dv/quad_encoder_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every encoder report and compares it with the block's output.
module quad_encoder_checker
    import qienc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  item_t              item,
    input  logic               empty,
    input  logic               pop,
    input  result_t            result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic signed [15:0] cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    logic [COUNT_W-1:0]        a_edges;
    logic [COUNT_W-1:0]        b_edges;
    logic [COUNT_W-1:0]        revolutions;
    logic signed [COUNT_W-1:0] angle;
    logic signed [15:0]        cal_offset;
    logic [TIME_W-1:0]         last_stamp;
    logic [SPEED_W-1:0]        speed;
    logic                      speed_ok;
    result_t                   pending_reports[$];
    result_t                   oldest;

    function automatic result_t advance_encoder(input item_t ev);
        result_t           rep;
        logic [TIME_W-1:0] period;
        case (ev.op)
            OP_A:
            begin
                a_edges = a_edges + 1'b1;
                angle   = ev.b_level ? angle + 1'b1 : angle - 1'b1;
            end
            OP_B:
            begin
                b_edges = b_edges + 1'b1;
            end
            OP_Z:
            begin
                revolutions = revolutions + 1'b1;
                a_edges     = '0;
                b_edges     = '0;
                angle       = COUNT_W'(cal_offset);
                period      = ev.timestamp_us - last_stamp;
                last_stamp  = ev.timestamp_us;
                if (period == '0)
                begin
                    speed_ok = 1'b0;
                    speed    = '0;
                end
                else
                begin
                    speed_ok = 1'b1;
                    speed    = SPEED_W'(TIME_W'(SPEED_NUM) / period);
                end
            end
            default:
            begin
            end
        endcase
        rep.position    = angle;
        rep.count_a     = a_edges;
        rep.count_b     = b_edges;
        rep.count_index = revolutions;
        rep.rpm         = speed_ok ? speed : '0;
        rep.rpm_valid   = speed_ok;
        rep.phase_error = ({1'b0, a_edges} > {1'b0, b_edges} + 17'd1) ||
                          ({1'b0, b_edges} > {1'b0, a_edges} + 17'd1);
        return rep;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            if (mismatches < 10)
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_edges     = '0;
            b_edges     = '0;
            revolutions = '0;
            angle       = '0;
            cal_offset  = '0;
            last_stamp  = '0;
            speed       = '0;
            speed_ok    = 1'b0;
            mismatches  = 0;
            pending_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: report beat with no expectation waiting", $time);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_reports.pop_front();
                    compare_field("position", oldest.position, result.position);
                    compare_field("count_a", oldest.count_a, result.count_a);
                    compare_field("count_b", oldest.count_b, result.count_b);
                    compare_field("count_index", oldest.count_index, result.count_index);
                    compare_field("rpm", oldest.rpm, result.rpm);
                    compare_field("rpm_valid", oldest.rpm_valid, result.rpm_valid);
                    compare_field("phase_error", oldest.phase_error, result.phase_error);
                end
            end
            if (push && !full)
                pending_reports.push_back(advance_encoder(item));
            if (cfg_valid && cfg_ready)
                cal_offset = cfg_data;
            outstanding <= pending_reports.size();
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top that drives encoder events and offset writes and reports the verdict.
module tb
    import qienc_pkg::*;
();

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         RANDOM_ITEMS = 400;
    localparam int         TAIL_CYCLES  = 50;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    item_t              item;
    logic               empty;
    logic               pop = 1'b0;
    result_t            result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic signed [15:0] cfg_data;
    int                 mismatches;
    int                 outstanding;

    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    int                 burst_left = 0;
    int                 rx_left = 0;
    int                 idle_cycles = 0;
    logic [31:0]        stamp_now = '0;

    always #5 clk = ~clk;

    quadrature_index_encoder_rpm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    quad_encoder_checker report_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        if (rx_steady)
            pop <= 1'b1;
        else if (rx_left != 0)
            rx_left <= rx_left - 1;
        else
        begin
            pop     <= !pop;
            rx_left <= pop ? $urandom_range(0, 12) : $urandom_range(0, 20);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic [1:0] kind, input logic level, input logic [31:0] stamp);
        if (!tx_steady && burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
            burst_left--;
        push <= 1'b1;
        item <= '{op: kind, b_level: level, timestamp_us: stamp};
        do @(posedge clk); while (full);
    endtask

    task automatic send_index();
        case ($urandom_range(0, 7))
            0:
            begin
            end
            1: stamp_now = $urandom;
            2: stamp_now = stamp_now + $urandom_range(1, 100);
            3: stamp_now = stamp_now + 32'd59999999 + $urandom_range(0, 2);
            4: stamp_now = stamp_now + $urandom;
            default: stamp_now = stamp_now + $urandom_range(1, 2000000);
        endcase
        send_item(OP_Z, 1'($urandom_range(0, 1)), stamp_now);
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_offset(input logic signed [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int target);
        int         done;
        int         run;
        bit         dir;
        logic [1:0] kind;
        done = 0;
        while (done < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                dir = 1'($urandom_range(0, 1));
                run = $urandom_range(2, 40);
                for (int i = 0; i < run; i++)
                begin
                    if (i % 2 == 0)
                        send_item(OP_A, ($urandom_range(0, 19) == 0) ? !dir : dir, $urandom);
                    else
                        send_item(OP_B, 1'($urandom_range(0, 1)), $urandom);
                    done++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_index();
                    done++;
                end
            end
            else
            begin
                kind = 2'($urandom_range(0, 3));
                case (kind)
                    OP_A, OP_B:
                    begin
                        send_item(kind, 1'($urandom_range(0, 1)), $urandom);
                        done++;
                    end
                    OP_Z:
                    begin
                        send_index();
                        done++;
                    end
                    default: send_item(OP_NONE, 1'($urandom_range(0, 1)), $urandom);
                endcase
            end
            if ($urandom_range(0, 150) == 0)
                settle();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        push      <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_NONE, 1'b1, '1);
        send_item(OP_A, 1'b1, '0);
        send_item(OP_A, 1'b1, '0);
        send_item(OP_B, 1'b0, '0);
        send_item(OP_B, 1'b0, '0);
        send_item(OP_A, 1'b0, '1);
        send_item(OP_Z, 1'b0, 32'd0);
        settle();
        write_offset(16'sh7fff);
        send_item(OP_Z, 1'b0, 32'd1);
        send_item(OP_A, 1'b1, '0);
        send_item(OP_A, 1'b0, '0);
        send_item(OP_Z, 1'b0, 32'd1);
        send_item(OP_Z, 1'b1, 32'hffff_ffff);
        send_item(OP_Z, 1'b0, 32'd5);
        send_item(OP_Z, 1'b0, 32'd60000005);
        send_item(OP_Z, 1'b0, 32'd120000006);
        settle();
        write_offset(-16'sh8000);
        send_item(OP_Z, 1'b0, 32'd180000005);
        send_item(OP_A, 1'b0, '0);
        send_item(OP_A, 1'b1, '0);
        send_item(OP_NONE, 1'b0, '0);
        stamp_now = 32'd180000005;
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            tx_steady = (phase == 1);
            rx_steady = (phase == 2);
            case (phase)
                0: write_offset(16'sh7fff);
                1: write_offset(-16'sh8000);
                2: write_offset(16'($urandom));
                default: write_offset(16'sd0);
            endcase
            random_phase(RANDOM_ITEMS);
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### quadrature_index_encoder_rpm.f
+incdir+rtl/core
rtl/core/qienc_pkg.sv
rtl/core/qienc_front.sv
rtl/core/qienc_back.sv
rtl/core/quadrature_index_encoder_rpm.sv
dv/quad_encoder_checker.sv
dv/tb.sv
